// ----- rtl/core/hsvg_pkg.sv -----
// Shared constants, types and helper functions for the HSV to GRB converter.
// No dependencies; every other file of the block takes its names from here.
`default_nettype none

package hsvg_pkg;

  // Pixel field width and the fixed scale points of the hexcone model.
  localparam int unsigned PixW      = 8;
  localparam int unsigned FullScale = 255;

  // Hue times six, and the sector boundaries on that scale.
  localparam int unsigned H6W       = 11;
  localparam logic [H6W-1:0] Bound1 = 11'd255;
  localparam logic [H6W-1:0] Bound2 = 11'd510;
  localparam logic [H6W-1:0] Bound3 = 11'd765;
  localparam logic [H6W-1:0] Bound4 = 11'd1020;
  localparam logic [H6W-1:0] Bound5 = 11'd1275;
  localparam logic [H6W-1:0] Bound6 = 11'd1530;

  // Widths of the products along the pipeline.
  localparam int unsigned SvW  = 16;   // s * v, at most 65025
  localparam int unsigned SvtW = 25;   // s * v * t plus rounding, below 2^24
  localparam int unsigned QW   = 17;   // first quotient estimate
  localparam int unsigned RemW = 10;   // remainder before correction, below 510

  // Which channel is dominant, intermediate and minimal, in that order.
  typedef enum logic [2:0] {
    SEC_RGB = 3'd0,
    SEC_GRB = 3'd1,
    SEC_GBR = 3'd2,
    SEC_BGR = 3'd3,
    SEC_BRG = 3'd4,
    SEC_RBG = 3'd5
  } sector_e;

  typedef logic [PixW-1:0] pix_t;

  // ceil(x / 255) for x up to 65025, by the shift-and-add reciprocal of 255.
  function automatic pix_t ceil_div255(input logic [SvW-1:0] x);
    logic [SvW:0] a;
    logic [SvW:0] b;
    a = {1'b0, x} + 17'd254;
    b = a + (a >> 8) + 17'd1;
    return b[15:8];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hsvg_if.sv -----
// Valid/ready channels that carry one HSV pixel in and one GRB pixel out.
// Depends on hsvg_pkg for the pixel type.
`default_nettype none

interface hsvg_in_if;
  logic             valid;
  logic             ready;
  hsvg_pkg::pix_t   hue;
  hsvg_pkg::pix_t   saturation;
  hsvg_pkg::pix_t   brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface hsvg_out_if;
  logic             valid;
  logic             ready;
  hsvg_pkg::pix_t   green_out;
  hsvg_pkg::pix_t   red_out;
  hsvg_pkg::pix_t   blue_out;

  modport source (output valid, output green_out, output red_out, output blue_out,
                  input ready);
  modport sink   (input valid, input green_out, input red_out, input blue_out,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/hsv_to_grb_pixel_converter.sv -----
// HSV to GRB pixel converter: five-stage pipeline, one beat in and one beat out per pixel.
// An accepted input beat passes through every stage register in turn to become a valid output beat.
// Throughput is one pixel per cycle; each stage holds its beat while the next is full and cannot advance.
// Reset (rst_ni low, asynchronous) clears only the stage valid bits; data is not reset.
// Depends on hsvg_pkg and on the hsvg_in_if / hsvg_out_if interfaces.
`default_nettype none

module hsv_to_grb_pixel_converter (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hsvg_in_if.sink    pix_i,
  hsvg_out_if.source pix_o
);

  // The work is split as follows.
  //   Stage 1: hue * 6, sector by comparison with the sector bounds, distance t from the
  //            midpoint of the double sector, and the 8 x 8 product s * v.
  //   Stage 2: the 16 x 8 product s * v * t, and the minimal channel v - ceil(sv/255).
  //   Stage 3: first estimate of ceil(svt/255) by the shift-and-add reciprocal;
  //            the estimate is low by at most one.
  //   Stage 4: remainder check and the one-step correction of that quotient.
  //   Stage 5: the second ceiling by 255 gives the intermediate channel, and the
  //            sector picks which of green, red and blue takes each value.
  // ceil(y/65025) equals ceil(ceil(y/255)/255), which is why the division is done twice.
  localparam int unsigned NumStages = 5;

  // Each stage advances when it is empty or when the stage after it advances.
  // Bubbles are thus squeezed out and a stalled output does not stop input beats
  // until every stage is full.
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] vld_d;
  logic [NumStages-1:0] adv;

  always_comb begin
    adv[NumStages-1] = !vld_q[NumStages-1] || pix_o.ready;
    for (int i = NumStages - 2; i >= 0; i--) begin
      adv[i] = !vld_q[i] || adv[i+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (adv[0]) begin
      vld_d[0] = pix_i.valid;
    end
    for (int i = 1; i < NumStages; i++) begin
      if (adv[i]) begin
        vld_d[i] = vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign pix_i.ready = adv[0];

  // ---------------------------------------------------------------- stage 1
  // Hue 255 lands on the full circle (hue*6 = 1530); it is folded back to the
  // first sector, where t is 255 and the intermediate channel equals the minimum.
  logic [hsvg_pkg::H6W-1:0] h6;
  logic [hsvg_pkg::H6W-1:0] ph_base;
  logic [hsvg_pkg::H6W-1:0] ph_full;
  logic [8:0]               ph;
  hsvg_pkg::sector_e        sec_d;
  hsvg_pkg::pix_t           t_d;
  logic [hsvg_pkg::SvW-1:0] sv_d;

  always_comb begin
    h6 = ({3'b000, pix_i.hue} << 2) + ({3'b000, pix_i.hue} << 1);

    if (h6 >= hsvg_pkg::Bound6) begin
      sec_d = hsvg_pkg::SEC_RGB;
    end else if (h6 >= hsvg_pkg::Bound5) begin
      sec_d = hsvg_pkg::SEC_RBG;
    end else if (h6 >= hsvg_pkg::Bound4) begin
      sec_d = hsvg_pkg::SEC_BRG;
    end else if (h6 >= hsvg_pkg::Bound3) begin
      sec_d = hsvg_pkg::SEC_BGR;
    end else if (h6 >= hsvg_pkg::Bound2) begin
      sec_d = hsvg_pkg::SEC_GBR;
    end else if (h6 >= hsvg_pkg::Bound1) begin
      sec_d = hsvg_pkg::SEC_GRB;
    end else begin
      sec_d = hsvg_pkg::SEC_RGB;
    end

    // hue*6 modulo 510, then the distance from the midpoint of the double sector.
    if (h6 >= hsvg_pkg::Bound6) begin
      ph_base = hsvg_pkg::Bound6;
    end else if (h6 >= hsvg_pkg::Bound4) begin
      ph_base = hsvg_pkg::Bound4;
    end else if (h6 >= hsvg_pkg::Bound2) begin
      ph_base = hsvg_pkg::Bound2;
    end else begin
      ph_base = '0;
    end
    ph_full = h6 - ph_base;
    ph      = ph_full[8:0];

    if (ph >= 9'd255) begin
      t_d = hsvg_pkg::pix_t'(ph - 9'd255);
    end else begin
      t_d = hsvg_pkg::pix_t'(9'd255 - ph);
    end

    sv_d = {8'h00, pix_i.saturation} * {8'h00, pix_i.brightness};
  end

  hsvg_pkg::sector_e        s1_sec_q;
  hsvg_pkg::pix_t           s1_t_q;
  logic [hsvg_pkg::SvW-1:0] s1_sv_q;
  hsvg_pkg::pix_t           s1_v_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s1_sec_q <= sec_d;
      s1_t_q   <= t_d;
      s1_sv_q  <= sv_d;
      s1_v_q   <= pix_i.brightness;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // The minimal channel never underflows, since ceil(s*v/255) is at most v.
  logic [23:0]    svt_d;
  hsvg_pkg::pix_t lo_d;

  assign svt_d = {8'h00, s1_sv_q} * {16'h0000, s1_t_q};
  assign lo_d  = s1_v_q - hsvg_pkg::ceil_div255(s1_sv_q);

  hsvg_pkg::sector_e s2_sec_q;
  logic [23:0]       s2_svt_q;
  hsvg_pkg::pix_t    s2_lo_q;
  hsvg_pkg::pix_t    s2_v_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s2_sec_q <= s1_sec_q;
      s2_svt_q <= svt_d;
      s2_lo_q  <= lo_d;
      s2_v_q   <= s1_v_q;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // w = svt + 254, so that floor(w/255) is the ceiling of svt/255. The series
  // w/256 + w/256^2 + w/256^3 sits just below w/255 and the truncations of its
  // terms can make the quotient one short, never more and never over.
  logic [hsvg_pkg::SvtW-1:0] w_d;
  logic [hsvg_pkg::SvtW-1:0] wsum;
  logic [hsvg_pkg::QW-1:0]   q0_d;

  always_comb begin
    w_d  = {1'b0, s2_svt_q} + 25'd254;
    wsum = w_d + (w_d >> 8) + (w_d >> 16);
    q0_d = wsum[hsvg_pkg::SvtW-1:8];
  end

  hsvg_pkg::sector_e         s3_sec_q;
  logic [hsvg_pkg::SvtW-1:0] s3_w_q;
  logic [hsvg_pkg::QW-1:0]   s3_q0_q;
  hsvg_pkg::pix_t            s3_lo_q;
  hsvg_pkg::pix_t            s3_v_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s3_sec_q <= s2_sec_q;
      s3_w_q   <= w_d;
      s3_q0_q  <= q0_d;
      s3_lo_q  <= s2_lo_q;
      s3_v_q   <= s2_v_q;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // Remainder against 255 * q0; a remainder of 255 or more means the estimate
  // was one short.
  logic [hsvg_pkg::SvtW-1:0] q255;
  logic [hsvg_pkg::SvtW-1:0] rem_full;
  logic [hsvg_pkg::RemW-1:0] rem;
  logic [hsvg_pkg::QW-1:0]   z_full;
  logic [hsvg_pkg::SvW-1:0]  z_d;

  always_comb begin
    q255     = ({8'h00, s3_q0_q} << 8) - {8'h00, s3_q0_q};
    rem_full = s3_w_q - q255;
    rem      = rem_full[hsvg_pkg::RemW-1:0];
    z_full   = s3_q0_q + {16'h0000, (rem >= 10'd255)};
    z_d      = z_full[hsvg_pkg::SvW-1:0];
  end

  hsvg_pkg::sector_e        s4_sec_q;
  logic [hsvg_pkg::SvW-1:0] s4_z_q;
  hsvg_pkg::pix_t           s4_lo_q;
  hsvg_pkg::pix_t           s4_v_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      s4_sec_q <= s3_sec_q;
      s4_z_q   <= z_d;
      s4_lo_q  <= s3_lo_q;
      s4_v_q   <= s3_v_q;
    end
  end

  // ---------------------------------------------------------------- stage 5
  // The second ceiling by 255 completes the intermediate channel; the sector then
  // routes dominant, intermediate and minimal onto red, green and blue.
  hsvg_pkg::pix_t mid;
  hsvg_pkg::pix_t hi;
  hsvg_pkg::pix_t r_d;
  hsvg_pkg::pix_t g_d;
  hsvg_pkg::pix_t b_d;

  always_comb begin
    hi  = s4_v_q;
    mid = s4_v_q - hsvg_pkg::ceil_div255(s4_z_q);
    case (s4_sec_q)
      hsvg_pkg::SEC_RGB: begin r_d = hi;      g_d = mid;     b_d = s4_lo_q; end
      hsvg_pkg::SEC_GRB: begin r_d = mid;     g_d = hi;      b_d = s4_lo_q; end
      hsvg_pkg::SEC_GBR: begin r_d = s4_lo_q; g_d = hi;      b_d = mid;     end
      hsvg_pkg::SEC_BGR: begin r_d = s4_lo_q; g_d = mid;     b_d = hi;      end
      hsvg_pkg::SEC_BRG: begin r_d = mid;     g_d = s4_lo_q; b_d = hi;      end
      default:           begin r_d = hi;      g_d = s4_lo_q; b_d = mid;     end
    endcase
  end

  hsvg_pkg::pix_t s5_g_q;
  hsvg_pkg::pix_t s5_r_q;
  hsvg_pkg::pix_t s5_b_q;

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      s5_g_q <= g_d;
      s5_r_q <= r_d;
      s5_b_q <= b_d;
    end
  end

  assign pix_o.valid     = vld_q[NumStages-1];
  assign pix_o.green_out = s5_g_q;
  assign pix_o.red_out   = s5_r_q;
  assign pix_o.blue_out  = s5_b_q;

  // ------------------------------------------------------------- assertions
  // The corrected quotient never exceeds 255 * 255, so the second ceiling fits.
  a_quot_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] |-> (s4_z_q <= 16'd65025))
    else $error("corrected quotient out of range");

  // The minimal channel is never above the dominant one.
  a_lo_le_v : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] |-> (s2_lo_q <= s2_v_q))
    else $error("minimal channel exceeds value");

  // An empty first stage always takes a beat.
  a_ready_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[0] |-> pix_i.ready)
    else $error("input stalled with empty first stage");

  // A beat held at the output because the sink stalled is still valid next cycle, with green and blue stable.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[4] && !pix_o.ready) |=> (vld_q[4] && $stable(s5_g_q) && $stable(s5_b_q)))
    else $error("output beat lost under stall");

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the HSV to GRB pixel converter: directed corners, random
// traffic with idling on both channels, full-rate bursts, a long output stall and a hue sweep.
// Depends on hsvg_pkg, the hsvg_in_if / hsvg_out_if channels and the converter RTL.

module tb_top;

  // Cycles without any beat on either channel before the run is declared hung. The
  // slowest legitimate quiet spell is the receiver hold-off below, so this is ample.
  localparam int unsigned StallLimit  = 2000;
  // Length of the deliberate receiver hold-off, long enough to fill every stage.
  localparam int unsigned HoldCycles  = 200;
  // Extra cycles after the last result, enough for all five stages to empty, to
  // catch any stray beat that the converter might still emit.
  localparam int unsigned DrainCycles = 12;

  typedef struct packed {
    hsvg_pkg::pix_t green;
    hsvg_pkg::pix_t red;
    hsvg_pkg::pix_t blue;
  } grb_pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  hsvg_in_if  in_ch ();
  hsvg_out_if out_ch ();

  hsv_to_grb_pixel_converter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (in_ch),
    .pix_o  (out_ch)
  );

  // Pixels still owed by the converter, oldest first.
  grb_pixel_t  pending_pixels[$];
  int unsigned error_count  = 0;
  int unsigned quiet_cycles = 0;

  // Idling switches for each side, and the request for one long output stall.
  bit send_gaps    = 1'b0;
  bit take_gaps    = 1'b0;
  bit hold_request = 1'b0;

  always #4 clk_i = ~clk_i;

  // Hexcone conversion in plain integer arithmetic. Hue times six picks the sector;
  // the triangle wave tri_lvl is 255 at hue*6 = 0, 510 and 1020, and 0 at 255, 765
  // and 1275, which sets the intermediate channel. Hue 255 lands on 1530, a seventh
  // sector that does not exist, so it wraps back to red.
  function automatic grb_pixel_t convert_hsv(input hsvg_pkg::pix_t hue,
                                             input hsvg_pkg::pix_t sat,
                                             input hsvg_pkg::pix_t val);
    int unsigned       hue6;
    int unsigned       sect_idx;
    int unsigned       phase;
    int unsigned       tri_lvl;
    int unsigned       sat_w;
    int unsigned       val_w;
    int unsigned       prod_sv;
    int unsigned       peak_lvl;
    int unsigned       floor_lvl;
    int unsigned       mid_lvl;
    hsvg_pkg::sector_e sector;
    grb_pixel_t        px;
    sat_w     = sat;
    val_w     = val;
    hue6      = int'(hue) * 6;
    sect_idx  = hue6 / 255;
    if (sect_idx >= 6) begin
      sect_idx = 0;
    end
    sector    = hsvg_pkg::sector_e'(sect_idx);
    phase     = hue6 % 510;
    tri_lvl   = (phase >= 255) ? phase - 255 : 255 - phase;
    prod_sv   = sat_w * val_w;
    peak_lvl  = val_w;
    // Both reductions round up, so the subtraction can never go below zero.
    floor_lvl = val_w - (prod_sv + 254) / 255;
    mid_lvl   = val_w - (prod_sv * tri_lvl + 65024) / 65025;
    case (sector)
      hsvg_pkg::SEC_RGB: begin
        px.red   = hsvg_pkg::pix_t'(peak_lvl);
        px.green = hsvg_pkg::pix_t'(mid_lvl);
        px.blue  = hsvg_pkg::pix_t'(floor_lvl);
      end
      hsvg_pkg::SEC_GRB: begin
        px.red   = hsvg_pkg::pix_t'(mid_lvl);
        px.green = hsvg_pkg::pix_t'(peak_lvl);
        px.blue  = hsvg_pkg::pix_t'(floor_lvl);
      end
      hsvg_pkg::SEC_GBR: begin
        px.red   = hsvg_pkg::pix_t'(floor_lvl);
        px.green = hsvg_pkg::pix_t'(peak_lvl);
        px.blue  = hsvg_pkg::pix_t'(mid_lvl);
      end
      hsvg_pkg::SEC_BGR: begin
        px.red   = hsvg_pkg::pix_t'(floor_lvl);
        px.green = hsvg_pkg::pix_t'(mid_lvl);
        px.blue  = hsvg_pkg::pix_t'(peak_lvl);
      end
      hsvg_pkg::SEC_BRG: begin
        px.red   = hsvg_pkg::pix_t'(mid_lvl);
        px.green = hsvg_pkg::pix_t'(floor_lvl);
        px.blue  = hsvg_pkg::pix_t'(peak_lvl);
      end
      default: begin
        px.red   = hsvg_pkg::pix_t'(peak_lvl);
        px.green = hsvg_pkg::pix_t'(floor_lvl);
        px.blue  = hsvg_pkg::pix_t'(mid_lvl);
      end
    endcase
    return px;
  endfunction

  // Mostly uniform, with a fair share of the two extremes where rounding is touchiest.
  function automatic hsvg_pkg::pix_t random_level();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return hsvg_pkg::pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Offers one pixel and returns at the edge where it is taken. Valid is only dropped
  // when a gap is drawn, so back-to-back beats keep it high without a glitch.
  task automatic send_pixel(input hsvg_pkg::pix_t hue, input hsvg_pkg::pix_t sat,
                            input hsvg_pkg::pix_t val);
    int unsigned gap;
    gap = send_gaps ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.hue        <= hue;
    in_ch.saturation <= sat;
    in_ch.brightness <= val;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_pixels.push_back(convert_hsv(hue, sat, val));
  endtask

  task automatic send_random_pixel();
    send_pixel(hsvg_pkg::pix_t'($urandom_range(0, 255)), random_level(), random_level());
  endtask

  // Stops offering and holds until the converter has delivered everything owed.
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  // Corners: black, white, grey, every sector and hues at or next to each sector edge,
  // the full-circle hue, and the smallest non-zero products.
  task automatic test_directed_corners();
    send_gaps = 1'b0;
    take_gaps = 1'b0;
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd100, 8'd0,   8'd200);
    send_pixel(8'd30,  8'd255, 8'd0);
    send_pixel(8'd42,  8'd255, 8'd255);
    send_pixel(8'd43,  8'd255, 8'd255);
    send_pixel(8'd85,  8'd255, 8'd255);
    send_pixel(8'd86,  8'd200, 8'd180);
    send_pixel(8'd127, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd255, 8'd255);
    send_pixel(8'd170, 8'd255, 8'd255);
    send_pixel(8'd171, 8'd100, 8'd250);
    send_pixel(8'd212, 8'd255, 8'd255);
    send_pixel(8'd213, 8'd255, 8'd255);
    send_pixel(8'd254, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd200, 8'd180);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd21,  8'd1,   8'd1);
    send_pixel(8'd64,  8'd255, 8'd1);
    send_pixel(8'd149, 8'd1,   8'd255);
    send_pixel(8'd191, 8'd128, 8'd128);
    send_pixel(8'd234, 8'd127, 8'd129);
    wait_for_results();
  endtask

  // Random pixels in chunks that walk through every combination of idling on the
  // two sides, so there are stretches with no gaps at all as well as ragged ones.
  task automatic test_random_traffic();
    for (int chunk = 0; chunk < 12; chunk++) begin
      send_gaps = chunk[0];
      take_gaps = chunk[1];
      for (int n = 0; n < 100; n++) begin
        send_random_pixel();
      end
    end
    wait_for_results();
  endtask

  // Both sides always ready, so the converter is driven at one pixel per cycle.
  task automatic test_full_rate();
    send_gaps = 1'b0;
    take_gaps = 1'b0;
    for (int n = 0; n < 400; n++) begin
      send_random_pixel();
    end
    wait_for_results();
  endtask

  // The receiver stops for a long spell while pixels keep coming, so every stage
  // fills and the input side has to stall; nothing may be lost or repeated.
  task automatic test_output_backpressure();
    send_gaps    = 1'b0;
    take_gaps    = 1'b0;
    hold_request = 1'b1;
    for (int n = 0; n < 60; n++) begin
      send_random_pixel();
    end
    wait_for_results();
  endtask

  // Every hue once, with random saturation and value and random idling.
  task automatic test_hue_sweep();
    send_gaps = 1'b1;
    take_gaps = 1'b1;
    for (int h = 0; h < 256; h++) begin
      send_pixel(hsvg_pkg::pix_t'(h), random_level(), random_level());
    end
    wait_for_results();
  endtask

  task automatic check_field(input string name, input hsvg_pkg::pix_t want,
                             input hsvg_pkg::pix_t got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  // Each output beat is matched against the oldest pixel still owed.
  always @(posedge clk_i) begin : check_results
    grb_pixel_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        $error("output beat with no pixel owed: green %0d red %0d blue %0d",
               out_ch.green_out, out_ch.red_out, out_ch.blue_out);
        error_count++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("green_out", want.green, out_ch.green_out);
        check_field("red_out",   want.red,   out_ch.red_out);
        check_field("blue_out",  want.blue,  out_ch.blue_out);
      end
    end
  end

  // Receiver. It draws a stall per beat when idling is on, and serves a pending
  // hold-off request by keeping ready low for the whole stretch, counted here.
  initial begin : receiver
    int unsigned stall;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_request = 1'b0;
      end
      stall = take_gaps ? $urandom_range(0, 15) : 0;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid && !hold_request);
    end
  end

  // Watchdog: a long run of cycles with no beat anywhere means the block has hung.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    rst_ni           <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.hue        <= '0;
    in_ch.saturation <= '0;
    in_ch.brightness <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_corners();
    test_random_traffic();
    test_full_rate();
    test_output_backpressure();
    test_hue_sweep();

    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
